>>> hw/rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared widths and controller/datapath command and status types for the
// multichannel moving-average filter.
// ----------------------------------------------------------------------------
package mma_pkg;

	localparam int SMP_W = 12;   // converter sample and average width
	localparam int CHN_W = 1;    // channel field width on the ports

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch the incoming transaction
		logic read;      // read the oldest ring entry of the channel
		logic update;    // write ring, update sum/position, load divider
		logic step;      // one restoring-division step
		logic out_load;  // move the quotient into the output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_last;  // current division step is the final one
	} dp_status_t;

endpackage

>>> hw/rtl/mma_in_if.sv
// ----------------------------------------------------------------------------
// mma_in_if
// Sample channel: valid/ready handshake with channel number and sample.
// ----------------------------------------------------------------------------
interface mma_in_if;
	import mma_pkg::*;

	logic             valid;
	logic             ready;
	logic [CHN_W-1:0] channel;
	logic [SMP_W-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink   (input valid, input channel, input sample, output ready);

endinterface

>>> hw/rtl/mma_out_if.sv
// ----------------------------------------------------------------------------
// mma_out_if
// Result channel: valid/ready handshake with channel number and average.
// ----------------------------------------------------------------------------
interface mma_out_if;
	import mma_pkg::*;

	logic             valid;
	logic             ready;
	logic [CHN_W-1:0] out_channel;
	logic [SMP_W-1:0] average;

	modport source (output valid, output out_channel, output average, input ready);
	modport sink   (input valid, input out_channel, input average, output ready);

endinterface

>>> hw/rtl/multichannel_moving_average.sv
// Division: the restoring divider yields one quotient bit per cycle;
//   SUM_W = clog2(WINDOW*4095+1).
// Flow: a new sample is taken only once the last one has left the sequencer; a result
//   waiting in the output register does not stop the next sample from entering.
// Reset: arst_n clears sums, ring positions, full flags and the sequencer; ring
//   entries are treated as zero until first written, so no clearing pass runs.
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Boxcar moving-average filter over 12-bit samples with an independent
// WINDOW-deep filter per channel.
// ----------------------------------------------------------------------------
module multichannel_moving_average #(
	parameter int WINDOW   = 50,   // samples per window, 1..255
	parameter int CHANNELS = 2     // independent filters, 1..2 (CHN_W = 1)
) (
	input logic      clk,
	input logic      arst_n,
	mma_in_if.sink   samples,
	mma_out_if.source averages
);
	import mma_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencer. Per transaction:
	//   IDLE   - take the sample and channel
	//   READ   - fetch the ring slot about to be overwritten
	//   UPDATE - sum = sum - oldest + new, write ring, advance position,
	//            set full on wrap, load divider with sum / count
	//   DIV    - SUM_W restoring-division steps
	//   HOLD   - wait until the output register is free, then load it
	mma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (averages.valid),
		.out_ready (averages.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Datapath. The divisor is the count of samples seen so far, or WINDOW
	// once the ring has wrapped, so it is never zero. Before a wrap the slot
	// being replaced was never written and counts as zero.
	mma_datapath #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_channel  (samples.channel),
		.in_sample   (samples.sample),
		.out_channel (averages.out_channel),
		.average     (averages.average)
	);

endmodule

>>> hw/rtl/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer: capture, ring read, update, iterative divide, result hand-off.
// Owns the input ready and the output valid flag.
// ----------------------------------------------------------------------------
module mma_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output mma_pkg::ctrl_cmd_t  cmd,
	input  mma_pkg::dp_status_t status
);
	import mma_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_HOLD   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_nx = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nx   = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (status.div_last)
					state_nx = ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/mma_datapath.sv
// ----------------------------------------------------------------------------
// mma_datapath
// Per-channel sums, ring positions and full flags, the sample ring memory,
// a one-bit-per-cycle restoring divider and the output register.
// ----------------------------------------------------------------------------
module mma_datapath #(
	parameter int WINDOW   = 50,
	parameter int CHANNELS = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mma_pkg::ctrl_cmd_t         cmd,
	output mma_pkg::dp_status_t        status,
	input  logic [mma_pkg::CHN_W-1:0]  in_channel,
	input  logic [mma_pkg::SMP_W-1:0]  in_sample,
	output logic [mma_pkg::CHN_W-1:0]  out_channel,
	output logic [mma_pkg::SMP_W-1:0]  average
);
	import mma_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = $clog2(WINDOW * ((1 << SMP_W) - 1) + 1);
	localparam int DEPTH  = CHANNELS * WINDOW;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int STEP_W = $clog2(SUM_W);

	// captured transaction
	logic [CHN_W-1:0] ch_q;
	logic [SMP_W-1:0] smp_q;
	logic             ok_q;
	logic [SMP_W-1:0] rd_q;

	// per-channel filter state
	logic [SUM_W-1:0] sum_q  [CHANNELS];
	logic [POS_W-1:0] pos_q  [CHANNELS];
	logic             full_q [CHANNELS];

	// sample ring, one WINDOW-deep segment per channel
	logic [SMP_W-1:0] ring_mem [DEPTH];

	// divider
	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] div_q;
	logic [STEP_W-1:0] step_q;

	logic [CHN_W-1:0] out_channel_q;
	logic [SMP_W-1:0] average_q;

	logic [CH_W-1:0]  chi;
	logic [AW-1:0]    addr;
	logic [POS_W-1:0] cur_pos;
	logic             cur_full;
	logic [SUM_W-1:0] cur_sum;
	logic [SMP_W-1:0] old_smp;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_nx;
	logic             wrap;
	logic [POS_W-1:0] pos_nx;
	logic             full_nx;
	logic [CNT_W-1:0] count;
	logic [CNT_W:0]   shifted;
	logic [CNT_W:0]   diff;
	logic             fits;

	assign chi      = ok_q ? CH_W'(ch_q) : '0;
	assign cur_pos  = pos_q[chi];
	assign cur_full = full_q[chi];
	assign cur_sum  = sum_q[chi];
	assign addr     = AW'(int'(chi) * WINDOW + int'(cur_pos));

	// slots not yet written since reset read as zero
	assign old_smp  = cur_full ? rd_q : '0;
	assign sum_wide = {1'b0, cur_sum} - (SUM_W + 1)'(old_smp) + (SUM_W + 1)'(smp_q);
	assign sum_nx   = sum_wide[SUM_W-1:0];
	assign wrap     = (cur_pos == POS_W'(WINDOW - 1));
	assign pos_nx   = wrap ? '0 : cur_pos + 1'b1;
	assign full_nx  = cur_full | wrap;
	assign count    = full_nx ? CNT_W'(WINDOW) : CNT_W'(pos_nx);

	assign shifted  = {rem_q, quo_q[SUM_W-1]};
	assign diff     = shifted - {1'b0, div_q};
	assign fits     = (shifted >= {1'b0, div_q});

	assign status.div_last = (step_q == STEP_W'(SUM_W - 1));
	assign out_channel     = out_channel_q;
	assign average         = average_q;

	always_ff @(posedge clk) begin
		if (cmd.read)
			rd_q <= ring_mem[addr];
		if (cmd.update && ok_q)
			ring_mem[addr] <= smp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]  <= '0;
				pos_q[i]  <= '0;
				full_q[i] <= 1'b0;
			end
		end else if (cmd.update && ok_q) begin
			sum_q[chi]  <= sum_nx;
			pos_q[chi]  <= pos_nx;
			full_q[chi] <= full_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q  <= in_channel;
			smp_q <= in_sample;
			ok_q  <= (int'(in_channel) < CHANNELS);
		end
		if (cmd.update) begin
			rem_q  <= '0;
			step_q <= '0;
			// channel outside the configured range reports zero
			quo_q  <= ok_q ? sum_nx : '0;
			div_q  <= ok_q ? count : CNT_W'(1);
		end else if (cmd.step) begin
			rem_q  <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], fits};
			step_q <= step_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_channel_q <= ch_q;
			average_q     <= quo_q[SMP_W-1:0];
		end
	end

endmodule

>>> hw/rtl/mma_checker.sv
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks for the moving-average filter, bound to the top level.
// ----------------------------------------------------------------------------
module mma_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [mma_pkg::CHN_W-1:0]  out_channel,
	input logic [mma_pkg::SMP_W-1:0]  average
);
	import mma_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (in_acc && !out_acc)
			pending_q <= pending_q + 1'b1;
		else if (out_acc && !in_acc)
			pending_q <= pending_q - 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_channel) && $stable(average))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second sample taken while one is in work");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two transactions outstanding");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result with no sample behind it");

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (averages.valid),
	.out_ready   (averages.ready),
	.out_channel (averages.out_channel),
	.average     (averages.average)
);

>>> sim/average_checker.sv
// ----------------------------------------------------------------------------
// average_checker
// Watches the sample and average channels, predicts each average from the
// accepted samples and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module average_checker #(
	parameter int WINDOW   = 50,
	parameter int CHANNELS = 2
) (
	input  logic clk,
	input  logic arst_n,
	mma_in_if    in_mon,
	mma_out_if   out_mon,
	output int   failures,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import mma_pkg::*;

	typedef struct packed {
		logic [CHN_W-1:0] ch;
		logic [SMP_W-1:0] avg;
	} avg_rec_t;

	// predictor state, one filter per channel
	logic [SMP_W-1:0] window_store [CHANNELS][WINDOW];
	int unsigned      window_sum   [CHANNELS];
	int unsigned      write_slot   [CHANNELS];
	logic             wrapped      [CHANNELS];

	avg_rec_t expected_averages[$];

	initial begin
		failures    = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		failures++;
	endtask

	function automatic avg_rec_t predict_average(input logic [CHN_W-1:0] ch,
		input logic [SMP_W-1:0] smp);
		avg_rec_t    r;
		int unsigned slot;
		int unsigned divisor;
		r.ch  = ch;
		r.avg = '0;
		// channel with no filter behind it: state untouched, average zero
		if (int'(ch) >= CHANNELS)
			return r;
		slot = write_slot[ch];
		// unwritten slots hold zero, so the oldest-sample subtraction is harmless
		window_sum[ch] = window_sum[ch] - window_store[ch][slot] + smp;
		window_store[ch][slot] = smp;
		slot++;
		if (slot >= WINDOW) begin
			slot = 0;
			wrapped[ch] = 1'b1;
		end
		write_slot[ch] = slot;
		divisor = wrapped[ch] ? WINDOW : slot;
		r.avg = SMP_W'(window_sum[ch] / divisor);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		avg_rec_t got;
		avg_rec_t want;
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				window_sum[c] = 0;
				write_slot[c] = 0;
				wrapped[c]    = 1'b0;
				for (int s = 0; s < WINDOW; s++)
					window_store[c][s] = '0;
			end
			expected_averages.delete();
			outstanding = 0;
		end else begin
			// results first: anything leaving now stems from an earlier sample
			if (out_mon.valid && out_mon.ready) begin
				got.ch  = out_mon.out_channel;
				got.avg = out_mon.average;
				if (expected_averages.size() == 0) begin
					report_mismatch($sformatf("unexpected average ch=%0d avg=%0d",
						got.ch, got.avg));
				end else begin
					want = expected_averages.pop_front();
					if (got.ch !== want.ch)
						report_mismatch($sformatf("out_channel %0d, expected %0d",
							got.ch, want.ch));
					if (got.avg !== want.avg)
						report_mismatch($sformatf("average %0d on ch %0d, expected %0d",
							got.avg, want.ch, want.avg));
				end
			end
			if (in_mon.valid && in_mon.ready)
				expected_averages.push_back(predict_average(in_mon.channel, in_mon.sample));
			outstanding = expected_averages.size();
		end
	end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives samples into the moving-average filter and lets the result side
// stall at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mma_pkg::*;

	localparam int WINDOW       = 50;
	localparam int CHANNELS     = 2;
	localparam int RANDOM_ITEMS = 1500;
	localparam int CALM_TAIL    = 200;   // final transactions with no idling at all
	localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
	localparam int DRAIN_CYCLES = 40;    // wait after the last result before the verdict

	logic clk = 1'b0;
	logic arst_n;

	mma_in_if  in_bus();
	mma_out_if out_bus();

	int  failures;
	int  outstanding;

	// stimulus settings; calm and stall_requests are also read by the ready process
	bit  calm;            // no idling on either side
	int  gap_chance;      // sender gap odds per transaction, 0 = none
	int  stall_requests;  // bumped by stimulus, served by the ready process

	// directed transactions: {channel, sample}
	logic [CHN_W+SMP_W-1:0] directed_items [20] = '{
		{1'b0, 12'h000}, {1'b1, 12'hFFF}, {1'b0, 12'hFFF}, {1'b1, 12'h000},
		{1'b0, 12'h001}, {1'b1, 12'h800}, {1'b0, 12'hAAA}, {1'b1, 12'h555},
		{1'b0, 12'h7FF}, {1'b1, 12'hFFE}, {1'b0, 12'hFFF}, {1'b0, 12'hFFF},
		{1'b0, 12'h000}, {1'b1, 12'h001}, {1'b1, 12'hFFF}, {1'b0, 12'h123},
		{1'b1, 12'hABC}, {1'b0, 12'hFFF}, {1'b1, 12'hFFF}, {1'b0, 12'h000}
	};

	always #5 clk = ~clk;

	multichannel_moving_average #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (in_bus),
		.averages (out_bus)
	);

	average_checker #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mon      (in_bus),
		.out_mon     (out_bus),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Sample values lean hard on the extremes and single-bit patterns.
	function automatic logic [SMP_W-1:0] pick_sample();
		logic [SMP_W-1:0] one_hot;
		one_hot = SMP_W'(1) << $urandom_range(0, SMP_W-1);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return one_hot;
			3:       return ~one_hot;
			default: return SMP_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// Offer one transaction, hold it until accepted, then maybe pause.
	// Called and returns at a falling edge; valid stays high unless a gap follows.
	task automatic send_sample(input logic [CHN_W-1:0] ch, input logic [SMP_W-1:0] smp);
		int gap;
		in_bus.valid   <= 1'b1;
		in_bus.channel <= ch;
		in_bus.sample  <= smp;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		@(negedge clk);
		if (!calm && gap_chance != 0 && $urandom_range(1, gap_chance) == 1) begin
			gap = $urandom_range(1, 12);
			in_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop offering and let every outstanding average come back.
	task automatic drain_results();
		in_bus.valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	// Result-side ready: bursts of stall and accept, plus the long hold-off
	// on request. All counting happens here, on falling edges.
	initial begin
		int hold_left;
		int run_left;
		int stalls_served;
		hold_left     = 0;
		run_left      = 0;
		stalls_served = 0;
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stalls_served != stall_requests) begin
				stalls_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				out_bus.ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else if (!calm) begin
					hold_left = $urandom_range(1, 12);
					// now and then a long stretch with no stalls
					run_left  = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
				end
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int sent;
		int kind;
		int seg_len;
		logic [CHN_W-1:0] seg_ch;
		logic [SMP_W-1:0] level;
		in_bus.valid   = 1'b0;
		in_bus.channel = '0;
		in_bus.sample  = '0;
		calm           = 1'b0;
		gap_chance     = 4;
		stall_requests = 0;
		arst_n         = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: first samples of each channel (empty slots, divisor 1, 2, ...),
		// field extremes and bit patterns on both channels.
		foreach (directed_items[i])
			send_sample(directed_items[i][CHN_W+SMP_W-1 -: CHN_W],
				directed_items[i][SMP_W-1:0]);
		drain_results();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			kind       = $urandom_range(0, 3);
			seg_ch     = CHN_W'($urandom_range(0, 1));
			level      = $urandom_range(0, 1) ? '1 : '0;
			gap_chance = $urandom_range(0, 4);
			// constant runs span at least a window to hit the full sum and zero
			seg_len    = (kind == 1) ? $urandom_range(WINDOW, WINDOW + 20)
			                         : $urandom_range(1, 40);
			for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
				if (sent == RANDOM_ITEMS - CALM_TAIL)
					calm = 1'b1;
				// receiver holds off while transactions keep coming: block backs up
				if (sent == 300 || sent == 900)
					stall_requests++;
				// sender waits for the pipeline to empty
				if (sent == 600 || sent == 1100)
					drain_results();
				case (kind)
					0:       send_sample(CHN_W'($urandom_range(0, 1)), pick_sample());
					1:       send_sample(seg_ch, level);
					2:       send_sample(seg_ch, pick_sample());
					default: send_sample(seg_ch ^ CHN_W'(i[0]), pick_sample());
				endcase
				sent++;
			end
		end
		in_bus.valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: a run that has not finished by the time limit below ends as failed.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
